// ===== hw/rtl/urdc_pkg.sv =====
// Shared types, constants and the CRC-8 byte step for the register datagram codec.
package urdc_pkg;

  localparam int unsigned URDC_BUDGET      = 16;
  localparam int unsigned URDC_QUEUE_DEPTH = 4;

  localparam logic [7:0] SYNC_BYTE   = 8'h05;
  localparam logic [7:0] MASTER_ADDR = 8'hFF;
  localparam logic [7:0] WRITE_FLAG  = 8'h80;
  localparam logic [7:0] CRC_POLY    = 8'h07;

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_READ    = 2'd1,
    ACT_RX_BYTE = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_TX        = 3'd0,
    ST_SEARCH    = 3'd1,
    ST_FOUND     = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_IGNORED   = 3'd4
  } status_e;

  // One queued job: a datagram to send, or a single status result
  typedef struct packed {
    status_e     status;
    logic        long_frame;
    logic [1:0]  node;
    logic [7:0]  reg_byte;
    logic [31:0] value;
  } cmd_t;

  // CRC-8, polynomial 0x07, data fed LSB first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    int         b;
    c = crc;
    d = data;
    for (b = 0; b < 8; b++) begin
      if (c[7] ^ d[0]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
      d = {1'b0, d[7:1]};
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/urdc_if.sv =====
// Valid/ready channel interfaces for the codec's input items and result items.
interface urdc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [6:0]  reg_address;
  logic [31:0] write_value;
  logic [7:0]  rx_byte;

  modport source (output valid, action, reg_address, write_value, rx_byte, input ready);
  modport sink   (input valid, action, reg_address, write_value, rx_byte, output ready);
endinterface

interface urdc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  tx_byte;
  logic        last;
  logic [31:0] reply_value;

  modport source (output valid, status, tx_byte, last, reply_value, input ready);
  modport sink   (input valid, status, tx_byte, last, reply_value, output ready);
endinterface

// ===== hw/rtl/urdc_front.sv =====
// Front end: accepts items, builds datagram jobs and runs the reply scanner.
module urdc_front #(
  parameter int unsigned REPLY_BYTE_BUDGET = urdc_pkg::URDC_BUDGET
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  urdc_in_if.sink        in_i,
  input  logic [1:0]     node_i,
  input  logic           full_i,
  output logic           push_o,
  output urdc_pkg::cmd_t cmd_o
);
  import urdc_pkg::*;

  localparam int unsigned CntW = $clog2(REPLY_BYTE_BUDGET + 1);

  logic                  armed_q, armed_d;
  logic [CntW-1:0]       rx_count_q, rx_count_d;
  logic [6:0]            exp_reg_q, exp_reg_d;
  // Last seven received bytes, oldest at index 0
  logic [6:0][7:0]       win_q, win_d;
  // lane_q[k] holds the CRC of the last k received bytes
  logic [7:1][7:0]       lane_q, lane_d;

  logic                  accept;
  logic [CntW-1:0]       count_inc;
  logic                  match;
  logic                  exhausted;
  logic                  scan_byte;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign push_o     = accept;

  assign count_inc = rx_count_q + CntW'(1);
  assign match     = (count_inc >= CntW'(8)) &&
                     (win_q[0] == SYNC_BYTE) &&
                     (win_q[1] == MASTER_ADDR) &&
                     (win_q[2] == {1'b0, exp_reg_q}) &&
                     (lane_q[7] == in_i.rx_byte);
  assign exhausted = (count_inc >= CntW'(REPLY_BYTE_BUDGET));
  assign scan_byte = (in_i.action == ACT_RX_BYTE) && armed_q;

  always_comb begin
    cmd_o = '{status: ST_IGNORED, long_frame: 1'b0, node: node_i,
              reg_byte: 8'h00, value: 32'h0};
    case (in_i.action)
      ACT_WRITE: begin
        cmd_o.status     = ST_TX;
        cmd_o.long_frame = 1'b1;
        cmd_o.reg_byte   = WRITE_FLAG | {1'b0, in_i.reg_address};
        cmd_o.value      = in_i.write_value;
      end
      ACT_READ: begin
        cmd_o.status   = ST_TX;
        cmd_o.reg_byte = {1'b0, in_i.reg_address};
      end
      ACT_RX_BYTE: begin
        if (armed_q) begin
          if (match) begin
            cmd_o.status = ST_FOUND;
            cmd_o.value  = {win_q[3], win_q[4], win_q[5], win_q[6]};
          end else if (exhausted) begin
            cmd_o.status = ST_EXHAUSTED;
          end else begin
            cmd_o.status = ST_SEARCH;
          end
        end
      end
      default: begin
        cmd_o.status = ST_IGNORED;
      end
    endcase
  end

  always_comb begin
    armed_d    = armed_q;
    rx_count_d = rx_count_q;
    exp_reg_d  = exp_reg_q;
    win_d      = win_q;
    lane_d     = lane_q;
    if (accept && (in_i.action == ACT_READ)) begin
      armed_d    = 1'b1;
      rx_count_d = '0;
      exp_reg_d  = in_i.reg_address;
      win_d      = '0;
      lane_d     = '0;
    end else if (accept && scan_byte) begin
      rx_count_d = count_inc;
      win_d      = {in_i.rx_byte, win_q[6:1]};
      lane_d[1]  = crc8_step(8'h00, in_i.rx_byte);
      for (int k = 2; k < 8; k++) begin
        lane_d[k] = crc8_step(lane_q[k-1], in_i.rx_byte);
      end
      // Disarm on a found reply or a spent budget
      if (match || exhausted) begin
        armed_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q    <= 1'b0;
      rx_count_q <= '0;
      exp_reg_q  <= '0;
      win_q      <= '0;
      lane_q     <= '0;
    end else begin
      armed_q    <= armed_d;
      rx_count_q <= rx_count_d;
      exp_reg_q  <= exp_reg_d;
      win_q      <= win_d;
      lane_q     <= lane_d;
    end
  end

endmodule

// ===== hw/rtl/urdc_fifo.sv =====
// Job queue between the front end and the result sequencer.
module urdc_fifo #(
  parameter int unsigned DEPTH = urdc_pkg::URDC_QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  urdc_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output urdc_pkg::cmd_t data_o,
  output logic           empty_o
);
  import urdc_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/urdc_back.sv =====
// Back end: queued jobs with running CRC, one result per cycle unless stalled.
module urdc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  urdc_pkg::cmd_t head_i,
  output logic           pop_o,
  urdc_out_if.source     out_o
);
  import urdc_pkg::*;

  logic        out_valid_q, out_valid_d;
  logic [2:0]  status_q;
  logic [7:0]  tx_q;
  logic        last_q;
  logic [31:0] value_q;
  logic [2:0]  idx_q, idx_d;
  logic [7:0]  crc_q, crc_d;

  logic        advance;
  logic        is_tx;
  logic        tx_last;
  logic        item_last;
  logic [7:0]  tx_sel;
  logic [7:0]  tx_cur;

  assign advance   = !empty_i && (!out_valid_q || out_o.ready);
  assign is_tx     = (head_i.status == ST_TX);
  assign tx_last   = head_i.long_frame ? (idx_q == 3'd7) : (idx_q == 3'd3);
  assign item_last = !is_tx || tx_last;
  assign pop_o     = advance && item_last;

  always_comb begin
    case (idx_q)
      3'd0:    tx_sel = SYNC_BYTE;
      3'd1:    tx_sel = {6'b0, head_i.node};
      3'd2:    tx_sel = head_i.reg_byte;
      3'd3:    tx_sel = head_i.value[31:24];
      3'd4:    tx_sel = head_i.value[23:16];
      3'd5:    tx_sel = head_i.value[15:8];
      3'd6:    tx_sel = head_i.value[7:0];
      default: tx_sel = 8'h00;
    endcase
  end

  // The frame's final byte is the CRC accumulated over the bytes before it
  assign tx_cur = tx_last ? crc_q : tx_sel;

  always_comb begin
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    crc_d       = crc_q;
    if (advance) begin
      out_valid_d = 1'b1;
      if (item_last) begin
        idx_d = '0;
        crc_d = '0;
      end else begin
        idx_d = idx_q + 3'd1;
        crc_d = crc8_step(crc_q, tx_cur);
      end
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      crc_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      crc_q       <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q <= head_i.status;
      tx_q     <= is_tx ? tx_cur : 8'h00;
      last_q   <= item_last;
      value_q  <= is_tx ? 32'h0 : head_i.value;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.tx_byte     = tx_q;
  assign out_o.last        = last_q;
  assign out_o.reply_value = value_q;

endmodule

// ===== hw/rtl/uart_register_datagram_codec.sv =====
// Top level of the single-wire UART register datagram codec (master side).
//
//   channel   dir  handshake        carries
//   in_i      in   valid/ready      action, reg_address, write_value, rx_byte
//   out_o     out  valid/ready      status, tx_byte, last, reply_value
//   cfg       in   cfg_we_i only    cfg_wdata_i = node_address
//
// The front end takes one item per clock while the job queue has room; the back
// end issues one result per clock unless the output stalls, so a write yields
// eight results, a read four and any other item one. Each accepted item passes
// the job queue, then the result register. Reset clears the scanner, queue and
// output stage at once; no clearing pass. A stalled output holds only the back
// end; the front keeps accepting until the queue fills.
module uart_register_datagram_codec #(
  parameter int unsigned REPLY_BYTE_BUDGET = urdc_pkg::URDC_BUDGET,
  parameter int unsigned QUEUE_DEPTH       = urdc_pkg::URDC_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  urdc_in_if.sink    in_i,
  urdc_out_if.source out_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i
);
  import urdc_pkg::*;

  logic [1:0] node_q;
  cmd_t       push_cmd;
  cmd_t       head_cmd;
  logic       push;
  logic       full;
  logic       pop;
  logic       empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q <= 2'd0;
    end else if (cfg_we_i) begin
      node_q <= cfg_wdata_i;
    end
  end

  urdc_front #(
    .REPLY_BYTE_BUDGET(REPLY_BYTE_BUDGET)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .node_i(node_q),
    .full_i(full),
    .push_o(push),
    .cmd_o (push_cmd)
  );

  urdc_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .full_o (full),
    .pop_i  (pop),
    .data_o (head_cmd),
    .empty_o(empty)
  );

  urdc_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .empty_i(empty),
    .head_i (head_cmd),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

// ===== hw/rtl/urdc_checker.sv =====
// Port-level checker for the codec and its bind to the top level.
module urdc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  status_i,
  input logic [7:0]  tx_byte_i,
  input logic        last_i,
  input logic [31:0] reply_value_i
);
  import urdc_pkg::*;

  // Hold a stalled result transaction unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
    $stable(tx_byte_i) && $stable(last_i) && $stable(reply_value_i))
    else $error("result changed while stalled");

  // Every non-transmit result ends its item
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_TX) |-> last_i)
    else $error("status result without last");

  // Only a found reply carries a value
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_FOUND) |-> (reply_value_i == 32'h0))
    else $error("reply value outside a found reply");

  // A byte that is not last is followed by more bytes of the same frame
  a_frame_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=> !out_valid_i || (status_i == ST_TX))
    else $error("frame interrupted by a status result");

endmodule

bind uart_register_datagram_codec urdc_checker u_urdc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .status_i     (out_o.status),
  .tx_byte_i    (out_o.tx_byte),
  .last_i       (out_o.last),
  .reply_value_i(out_o.reply_value)
);

// ===== sim/uart_register_datagram_codec_test.sv =====
// Self-checking testbench for the UART register datagram codec: predicts every result.
module uart_register_datagram_codec_test;
  timeunit 1ns;
  timeprecision 1ps;

  import urdc_pkg::*;

  localparam int unsigned BUDGET      = URDC_BUDGET;
  localparam logic [1:0]  ACT_UNUSED  = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = 4;

  typedef struct packed {
    status_e     status;
    logic [7:0]  tx_byte;
    logic        last;
    logic [31:0] reply_value;
  } codec_result_t;

  class datagram_scoreboard;
    codec_result_t pending_results[$];
    logic [1:0]    node;
    logic [7:0]    window[8];
    int unsigned   rx_count;
    bit            armed;
    logic [6:0]    want_reg;
    int unsigned   errors;

    function new();
      node     = '0;
      rx_count = 0;
      armed    = 1'b0;
      want_reg = '0;
      errors   = 0;
      foreach (window[i]) window[i] = '0;
    endfunction

    function void set_node(logic [1:0] value);
      node = value;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // CRC-8, poly 0x07, init 0, bytes fed LSB first
    function logic [7:0] crc8(logic [7:0] buffer[8], int unsigned len);
      logic [7:0] crc;
      logic [7:0] cur;
      crc = '0;
      for (int i = 0; i < len; i++) begin
        cur = buffer[i];
        for (int b = 0; b < 8; b++) begin
          if (crc[7] ^ cur[0]) begin
            crc = {crc[6:0], 1'b0} ^ CRC_POLY;
          end else begin
            crc = {crc[6:0], 1'b0};
          end
          cur = {1'b0, cur[7:1]};
        end
      end
      return crc;
    endfunction

    function void push_result(status_e status, logic [7:0] tx, logic last, logic [31:0] value);
      codec_result_t r;
      r.status      = status;
      r.tx_byte     = tx;
      r.last        = last;
      r.reply_value = value;
      pending_results.push_back(r);
    endfunction

    function void push_frame(logic [7:0] frame[8], int unsigned len);
      for (int i = 0; i < len; i++) begin
        push_result(ST_TX, frame[i], i == len - 1, '0);
      end
    endfunction

    // Returns 1 when the block only ignores the transaction
    function bit accept_item(logic [1:0] action, logic [6:0] reg_addr, logic [31:0] wval,
                             logic [7:0] rxb);
      logic [7:0] frame[8];
      bit         ignored;
      ignored = 1'b0;
      foreach (frame[i]) frame[i] = '0;
      case (action)
        ACT_WRITE: begin
          frame[0] = SYNC_BYTE;
          frame[1] = {6'b0, node};
          frame[2] = WRITE_FLAG | {1'b0, reg_addr};
          frame[3] = wval[31:24];
          frame[4] = wval[23:16];
          frame[5] = wval[15:8];
          frame[6] = wval[7:0];
          frame[7] = crc8(frame, 7);
          push_frame(frame, 8);
        end
        ACT_READ: begin
          frame[0] = SYNC_BYTE;
          frame[1] = {6'b0, node};
          frame[2] = {1'b0, reg_addr};
          frame[3] = crc8(frame, 3);
          push_frame(frame, 4);
          foreach (window[i]) window[i] = '0;
          rx_count = 0;
          armed    = 1'b1;
          want_reg = reg_addr;
        end
        ACT_RX_BYTE: begin
          if (armed) begin
            for (int i = 0; i < 7; i++) window[i] = window[i + 1];
            window[7] = rxb;
            rx_count++;
            // a match on the budget byte wins over exhaustion
            if (rx_count >= 8 && window[0] == SYNC_BYTE && window[1] == MASTER_ADDR &&
                window[2] == {1'b0, want_reg} && crc8(window, 7) == window[7]) begin
              armed = 1'b0;
              push_result(ST_FOUND, '0, 1'b1, {window[3], window[4], window[5], window[6]});
            end else if (rx_count >= BUDGET) begin
              armed = 1'b0;
              push_result(ST_EXHAUSTED, '0, 1'b1, '0);
            end else begin
              push_result(ST_SEARCH, '0, 1'b1, '0);
            end
          end else begin
            ignored = 1'b1;
            push_result(ST_IGNORED, '0, 1'b1, '0);
          end
        end
        default: begin
          ignored = 1'b1;
          push_result(ST_IGNORED, '0, 1'b1, '0);
        end
      endcase
      return ignored;
    endfunction

    task report(string what);
      errors++;
      if (errors <= 100) $display("mismatch: %s", what);
    endtask

    task compare_result(logic [2:0] status, logic [7:0] tx, logic last, logic [31:0] value);
      codec_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing expected: status %0d tx %02h", status, tx));
        return;
      end
      want = pending_results.pop_front();
      if (status !== want.status)
        report($sformatf("status %0d, expected %0d", status, want.status));
      if (tx !== want.tx_byte)
        report($sformatf("tx_byte %02h, expected %02h", tx, want.tx_byte));
      if (last !== want.last)
        report($sformatf("last %0b, expected %0b", last, want.last));
      if (value !== want.reply_value)
        report($sformatf("reply_value %08h, expected %08h", value, want.reply_value));
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_wdata_i;

  urdc_in_if  in_ch ();
  urdc_out_if out_ch ();

  datagram_scoreboard sb = new();

  int unsigned send_idle_pct    = 0;
  int unsigned recv_idle_pct    = 0;
  int unsigned hold_off_trigger = 0;
  int unsigned items_sent       = 0;
  int unsigned cycle_count      = 0;

  uart_register_datagram_codec #(
    .REPLY_BYTE_BUDGET(BUDGET)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result receiver: random stalls, plus a long hold-off on request
  initial begin
    int unsigned hold_seen;
    int unsigned stall_left;
    hold_seen    = 0;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_trigger != hold_seen) begin
        hold_seen  = hold_off_trigger;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      sb.compare_result(out_ch.status, out_ch.tx_byte, out_ch.last, out_ch.reply_value);
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [6:0] pick_reg();
    case ($urandom_range(0, 3))
      0:       return 7'd0;
      1:       return 7'd127;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  // Leaves valid high; the caller lowers it or offers the next transaction
  task automatic send_item(logic [1:0] action, logic [6:0] reg_addr, logic [31:0] wval,
                           logic [7:0] rxb);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= action;
    in_ch.reg_address <= reg_addr;
    in_ch.write_value <= wval;
    in_ch.rx_byte     <= rxb;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    void'(sb.accept_item(action, reg_addr, wval, rxb));
    items_sent++;
  endtask

  task automatic send_noise_byte();
    send_item(ACT_RX_BYTE, 7'($urandom), $urandom, 8'($urandom));
  endtask

  task automatic send_reply(logic [6:0] reg_addr, logic [31:0] value, bit corrupt);
    logic [7:0] frame[8];
    frame[0] = SYNC_BYTE;
    frame[1] = MASTER_ADDR;
    frame[2] = {1'b0, reg_addr};
    frame[3] = value[31:24];
    frame[4] = value[23:16];
    frame[5] = value[15:8];
    frame[6] = value[7:0];
    frame[7] = sb.crc8(frame, 7);
    if (corrupt) frame[$urandom_range(0, 7)] ^= 8'h01 << $urandom_range(0, 7);
    foreach (frame[i]) send_item(ACT_RX_BYTE, 7'($urandom), $urandom, frame[i]);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_node(logic [1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_node(value);
  endtask

  task automatic random_sequence();
    int unsigned kind;
    logic [6:0]  target;
    kind   = $urandom_range(0, 99);
    target = pick_reg();
    if (kind < 50) begin
      // read transaction: request, noise and the odd write, then a possibly corrupt reply
      send_item(ACT_READ, target, $urandom, 8'($urandom));
      repeat ($urandom_range(0, 9)) begin
        if ($urandom_range(0, 9) == 0) send_item(ACT_WRITE, pick_reg(), pick_word(), 8'($urandom));
        else send_noise_byte();
      end
      send_reply(target, pick_word(), $urandom_range(0, 4) == 0);
    end else if (kind < 62) begin
      send_item(ACT_READ, target, $urandom, 8'($urandom));
      repeat ($urandom_range(1, 18)) send_noise_byte();
    end else if (kind < 82) begin
      send_item(ACT_WRITE, target, pick_word(), 8'($urandom));
    end else if (kind < 92) begin
      if ($urandom_range(0, 1) == 1) send_item(ACT_UNUSED, target, $urandom, 8'($urandom));
      else send_noise_byte();
    end else begin
      send_item(ACT_READ, target, $urandom, 8'($urandom));
      send_item(ACT_READ, pick_reg(), $urandom, 8'($urandom));
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    in_ch.valid       = 1'b0;
    in_ch.action      = '0;
    in_ch.reg_address = '0;
    in_ch.write_value = '0;
    in_ch.rx_byte     = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 14;
    recv_idle_pct = 57;
    write_node(2'd3);

    // directed: stray byte, unused code, write extremes, restart, write while armed
    send_item(ACT_RX_BYTE, 7'd0, 32'h0, 8'hFF);
    send_item(ACT_UNUSED, 7'd127, 32'hFFFF_FFFF, 8'h00);
    send_item(ACT_WRITE, 7'd0, 32'h0000_0000, 8'h00);
    send_item(ACT_WRITE, 7'd127, 32'hFFFF_FFFF, 8'hFF);
    send_item(ACT_READ, 7'd127, 32'h0, 8'h00);
    send_item(ACT_RX_BYTE, 7'd0, 32'h0, SYNC_BYTE);
    send_item(ACT_RX_BYTE, 7'd0, 32'h0, MASTER_ADDR);
    send_item(ACT_RX_BYTE, 7'd0, 32'h0, 8'h7F);
    send_item(ACT_READ, 7'd0, 32'h0, 8'h00);
    send_item(ACT_WRITE, 7'h55, 32'hA5A5_5A5A, 8'h00);
    repeat (8) send_noise_byte();
    // reply completes on the budget byte
    send_reply(7'd0, 32'hFFFF_FFFF, 1'b0);

    while (items_sent < 88) random_sequence();
    wait_drained();

    write_node(2'd0);
    send_idle_pct = 57;
    recv_idle_pct = 14;
    while (items_sent < 150) random_sequence();
    wait_drained();

    write_node(2'd1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_trigger++;
    while (items_sent < 181) random_sequence();
    wait_drained();

    write_node(2'd2);
    while (items_sent < 212) random_sequence();
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/urdc_pkg.sv
hw/rtl/urdc_if.sv
hw/rtl/urdc_front.sv
hw/rtl/urdc_fifo.sv
hw/rtl/urdc_back.sv
hw/rtl/uart_register_datagram_codec.sv
hw/rtl/urdc_checker.sv
sim/uart_register_datagram_codec_test.sv
